FILE: hdl/tdht_pkg.sv
`default_nettype none

package tdht_pkg;

	localparam int HISTORY_ENTRIES = 32;
	localparam int PAGE_SLOTS      = 64;
	localparam int BLOCKS_PER_PAGE = 64;
	localparam int TIME_BITS       = 16;
	localparam int MAX_DELTAS      = 8;

	// field widths on the ports
	localparam int PAGE_IN_W = 6;
	localparam int OFF_W     = 6;
	localparam int STAMP_W   = 16;
	localparam int LAT_W     = 16;
	localparam int START_W   = 16;
	localparam int DELTA_W   = 7;

	localparam int IDX_W  = $clog2(HISTORY_ENTRIES);
	localparam int CNT_W  = $clog2(HISTORY_ENTRIES + 1);
	localparam int EMIT_W = $clog2(MAX_DELTAS + 1);

	// stored page must hold any port value and the null marker
	localparam int PG_W = ($clog2(PAGE_SLOTS + 1) > PAGE_IN_W + 1) ?
		$clog2(PAGE_SLOTS + 1) : PAGE_IN_W + 1;
	localparam logic [PG_W-1:0] NULL_PAGE = PG_W'(PAGE_SLOTS);

	localparam int ENTRY_W = PG_W + OFF_W + TIME_BITS;

	// request time plus wrap bias, wide enough for the window compare
	localparam int REQ_W = ((START_W > TIME_BITS) ? START_W : TIME_BITS) + 2;

	localparam logic [1:0] REQ_INSERT     = 2'd0;
	localparam logic [1:0] REQ_INVALIDATE = 2'd1;
	localparam logic [1:0] REQ_SEARCH     = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_INVALIDATE,
		OP_SEARCH
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic issue;
		logic write_ins;
		logic term;
	} dp_cmd_t;

	typedef struct packed {
		logic page_ok;
		logic offs_ok;
		logic advance;
		logic pend;
		logic dup;
		logic lim;
	} dp_st_t;

endpackage

`default_nettype wire

FILE: hdl/tdht_ram.sv
`default_nettype none

module tdht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/tdht_ctrl.sv
`default_nettype none

module tdht_ctrl import tdht_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] req_type,
	input  wire dp_st_t     st,
	output logic            in_stall,
	output dp_cmd_t         cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_FINISH
	} state_t;

	localparam logic [CNT_W-1:0] ALL_ENTRIES   = CNT_W'(HISTORY_ENTRIES);
	localparam logic [CNT_W-1:0] OLDER_ENTRIES = CNT_W'(HISTORY_ENTRIES - 1);

	state_t           state_q;
	op_t              op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] todo_q;
	logic             accept;
	logic             sweep_done;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	// stop early on a duplicate or at the delta limit; drain the read in flight
	assign sweep_done = ((cnt_q == todo_q) || st.dup || st.lim) && !st.pend;

	always_comb begin
		cmd           = '0;
		cmd.start     = accept;
		cmd.op        = op_q;
		cmd.issue     = (state_q == S_SWEEP) && (cnt_q != todo_q) && !st.dup && !st.lim
			&& st.advance;
		cmd.write_ins = (state_q == S_FINISH) && (op_q == OP_INSERT) && !st.dup;
		cmd.term      = (state_q == S_FINISH) && (op_q == OP_SEARCH) && !st.lim
			&& st.advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
			cnt_q   <= '0;
			todo_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (req_type)
							REQ_INSERT: begin
								if (st.page_ok && st.offs_ok) begin
									op_q    <= OP_INSERT;
									todo_q  <= ALL_ENTRIES;
									state_q <= S_SWEEP;
								end
							end
							REQ_INVALIDATE: begin
								if (st.page_ok) begin
									op_q    <= OP_INVALIDATE;
									todo_q  <= ALL_ENTRIES;
									state_q <= S_SWEEP;
								end
							end
							REQ_SEARCH: begin
								op_q   <= OP_SEARCH;
								todo_q <= OLDER_ENTRIES;
								if (st.page_ok && st.offs_ok) begin
									state_q <= S_SWEEP;
								end else begin
									state_q <= S_FINISH;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (cmd.issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (sweep_done) begin
						state_q <= (op_q == OP_INVALIDATE) ? S_IDLE : S_FINISH;
					end
				end
				S_FINISH: begin
					if (op_q != OP_SEARCH || st.lim || st.advance) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/tdht_dpath.sv
`default_nettype none

module tdht_dpath import tdht_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [PAGE_IN_W-1:0] page_slot,
	input  wire logic [OFF_W-1:0]     block_offset,
	input  wire logic [STAMP_W-1:0]   time_stamp,
	input  wire logic [LAT_W-1:0]     latency,
	input  wire logic [START_W-1:0]   start_time,
	input  wire logic                 out_stall,
	input  wire dp_cmd_t              cmd,
	output dp_st_t                    st,
	output logic                      out_valid,
	output logic signed [DELTA_W-1:0] delta,
	output logic [LAT_W-1:0]          cycle_gain,
	output logic                      found,
	output logic                      last_of_run
);

	localparam logic [REQ_W-1:0] WRAP_BIAS = REQ_W'(1) << TIME_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_ENTRIES - 1);
	localparam logic [EMIT_W-1:0] LAST_EMIT = EMIT_W'(MAX_DELTAS - 1);

	// request held for the whole transaction
	logic [PG_W-1:0]      page_q;
	logic [OFF_W-1:0]     offs_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [LAT_W-1:0]     lat_q;
	logic [REQ_W-1:0]     req_q;

	logic [IDX_W-1:0]     head_q;
	logic [IDX_W-1:0]     rd_addr_q;
	logic [HISTORY_ENTRIES-1:0] valid_q;

	logic                 p_valid_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic                 vld_s1;

	logic                 dup_q;
	logic                 lim_q;
	logic [EMIT_W-1:0]    emit_cnt_q;
	logic                 first_q;
	logic                 bias_q;
	logic [TIME_BITS-1:0] last_time_q;

	logic                 out_valid_q;
	logic [DELTA_W-1:0]   delta_q;
	logic [LAT_W-1:0]     saved_q;
	logic                 found_q;
	logic                 last_run_q;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic [ENTRY_W-1:0]   rd_data;

	logic                 advance;
	logic                 proc;
	logic [PG_W-1:0]      e_page;
	logic [OFF_W-1:0]     e_off;
	logic [TIME_BITS-1:0] e_time;
	logic                 page_hit;
	logic                 off_hit;
	logic                 bias_now;
	logic [REQ_W-1:0]     win_sum;
	logic [REQ_W-1:0]     lat_x;
	logic [REQ_W-1:0]     t_x;
	logic                 in_window;
	logic                 srch_proc;
	logic                 emit;
	logic                 inv_hit;
	logic                 out_load;
	logic [DELTA_W-1:0]   delta_d;

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	assign advance = !(out_valid_q && out_stall);

	// entries never written read as the null page with zero offset and time
	assign e_page = vld_s1 ? rd_data[ENTRY_W-1 -: PG_W] : NULL_PAGE;
	assign e_off  = vld_s1 ? rd_data[TIME_BITS +: OFF_W] : '0;
	assign e_time = vld_s1 ? rd_data[TIME_BITS-1:0] : '0;

	assign proc     = p_valid_s1 && advance && !dup_q && !lim_q;
	assign page_hit = (e_page == page_q);
	assign off_hit  = (e_off == offs_q);

	// sticky bias once the walk sees a time going up (timestamp wrap)
	assign bias_now  = bias_q || (!first_q && (last_time_q < e_time));
	assign win_sum   = req_q + (bias_now ? WRAP_BIAS : '0);
	assign lat_x     = REQ_W'(lat_q);
	assign t_x       = REQ_W'(e_time);
	// a window below zero wraps and accepts
	assign in_window = (win_sum < lat_x) || (t_x + lat_x <= win_sum);

	assign srch_proc = proc && (cmd.op == OP_SEARCH);
	assign emit      = srch_proc && page_hit && !off_hit && (req_q != '0) && in_window;
	assign inv_hit   = proc && (cmd.op == OP_INVALIDATE) && page_hit;
	assign out_load  = emit || cmd.term;
	assign delta_d   = DELTA_W'({1'b0, offs_q}) - DELTA_W'({1'b0, e_off});

	always_comb begin
		wr_en   = cmd.write_ins || inv_hit;
		wr_addr = cmd.write_ins ? head_q : addr_s1;
		wr_data = cmd.write_ins ? {page_q, offs_q, stamp_q} : {NULL_PAGE, e_off, e_time};
	end

	tdht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (HISTORY_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.issue),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	always_comb begin
		st         = '0;
		st.page_ok = (PG_W'(page_slot) < PG_W'(PAGE_SLOTS));
		st.offs_ok = ((OFF_W + 1)'(block_offset) < (OFF_W + 1)'(BLOCKS_PER_PAGE));
		st.advance = advance;
		st.pend    = p_valid_s1;
		st.dup     = dup_q;
		st.lim     = lim_q;
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q  <= PG_W'(page_slot);
			offs_q  <= block_offset;
			stamp_q <= TIME_BITS'(time_stamp);
			lat_q   <= latency;
		end
		if (cmd.issue) begin
			addr_s1 <= rd_addr_q;
			vld_s1  <= valid_q[rd_addr_q];
		end
		if (srch_proc) begin
			last_time_q <= e_time;
		end
		if (cmd.start) begin
			req_q <= REQ_W'(start_time);
		end else if (srch_proc && page_hit && off_hit) begin
			req_q <= t_x;
		end
		if (emit) begin
			delta_q    <= delta_d;
			saved_q    <= lat_q;
			found_q    <= 1'b1;
			last_run_q <= (emit_cnt_q == LAST_EMIT);
		end else if (cmd.term) begin
			delta_q    <= '0;
			saved_q    <= '0;
			found_q    <= 1'b0;
			last_run_q <= 1'b1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			rd_addr_q   <= '0;
			valid_q     <= '0;
			p_valid_s1  <= 1'b0;
			dup_q       <= 1'b0;
			lim_q       <= 1'b0;
			emit_cnt_q  <= '0;
			first_q     <= 1'b1;
			bias_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_addr_q  <= idx_prev(head_q);
				p_valid_s1 <= 1'b0;
				dup_q      <= 1'b0;
				lim_q      <= 1'b0;
				emit_cnt_q <= '0;
				first_q    <= 1'b1;
				bias_q     <= 1'b0;
			end else begin
				if (cmd.issue) begin
					rd_addr_q <= idx_prev(rd_addr_q);
				end
				if (advance) begin
					p_valid_s1 <= cmd.issue;
				end
				if (proc && (cmd.op == OP_INSERT) && page_hit && off_hit) begin
					dup_q <= 1'b1;
				end
				if (srch_proc) begin
					first_q <= 1'b0;
					bias_q  <= bias_now;
				end
				if (emit) begin
					emit_cnt_q <= emit_cnt_q + 1'b1;
					if (emit_cnt_q == LAST_EMIT) begin
						lim_q <= 1'b1;
					end
				end
			end
			if (cmd.write_ins) begin
				valid_q[head_q] <= 1'b1;
				head_q          <= idx_next(head_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign delta        = $signed(delta_q);
	assign cycle_gain   = saved_q;
	assign found        = found_q;
	assign last_of_run  = last_run_q;

`ifndef SYNTHESIS
	// never overwrite a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// a search that hit the delta limit gets no terminator
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.term |-> !lim_q && !emit)
		else $error("terminator after delta limit");

	// an empty result always closes the search
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> last_run_q)
		else $error("terminator not marked last");

	// the insert write and an invalidate write never collide
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_ins |-> !inv_hit && !dup_q)
		else $error("write port conflict");
`endif

endmodule

`default_nettype wire

FILE: hdl/timely_delta_history_table.sv
// Each in-range request walks the history ring through one registered RAM read,
// one entry a cycle while no result waits on a stalled output, which freezes the walk;
// a duplicate or the delta limit ends the walk early. A search's delta passes through
// the read address register and the RAM read before it reaches the output register.
// Reset clears the valid bits, head and control registers but not the RAM; unwritten
// entries read as null page, zero.
`default_nettype none

module timely_delta_history_table import tdht_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           req_type,
	input  wire logic [PAGE_IN_W-1:0] page_slot,
	input  wire logic [OFF_W-1:0]     block_offset,
	input  wire logic [STAMP_W-1:0]   time_stamp,
	input  wire logic [LAT_W-1:0]     latency,
	input  wire logic [START_W-1:0]   start_time,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [DELTA_W-1:0] delta,
	output logic [LAT_W-1:0]          cycle_gain,
	output logic                      found,
	output logic                      last_of_run
);

	dp_cmd_t cmd;
	dp_st_t  st;

	tdht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	tdht_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.page_slot    (page_slot),
		.block_offset (block_offset),
		.time_stamp   (time_stamp),
		.latency      (latency),
		.start_time   (start_time),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.delta        (delta),
		.cycle_gain   (cycle_gain),
		.found        (found),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tdht_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int TAIL_ITEMS  = 25;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 60;
	localparam int LONG_HOLD   = 300;

	typedef struct {
		logic [1:0]           kind;
		logic [PAGE_IN_W-1:0] page;
		logic [OFF_W-1:0]     offs;
		logic [STAMP_W-1:0]   stamp;
		logic [LAT_W-1:0]     lat;
		logic [START_W-1:0]   start;
		bit                   hold_back;
	} access_req_t;

	typedef struct {
		logic signed [DELTA_W-1:0] delta;
		logic [LAT_W-1:0]          saved;
		logic                      found;
		logic                      last;
	} delta_res_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_INSERT;
	logic [PAGE_IN_W-1:0] page_slot = '0;
	logic [OFF_W-1:0] block_offset = '0;
	logic [STAMP_W-1:0] time_stamp = '0;
	logic [LAT_W-1:0] latency = '0;
	logic [START_W-1:0] start_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DELTA_W-1:0] delta;
	logic [LAT_W-1:0] cycle_gain;
	logic found;
	logic last_of_run;

	access_req_t req_q[$];
	delta_res_t delta_q[$];

	// predictor's copy of the history ring
	logic [PG_W-1:0] ring_page[HISTORY_ENTRIES];
	logic [OFF_W-1:0] ring_off[HISTORY_ENTRIES];
	logic [TIME_BITS-1:0] ring_time[HISTORY_ENTRIES];
	int unsigned ring_ptr;

	logic in_fire;
	int items_taken;
	int errors = 0;
	int cycles = 0;
	int gap_left;
	int stall_left;
	int hold_left;
	bit held;

	timely_delta_history_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.page_slot(page_slot),
		.block_offset(block_offset),
		.time_stamp(time_stamp),
		.latency(latency),
		.start_time(start_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.delta(delta),
		.cycle_gain(cycle_gain),
		.found(found),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit tail_phase();
		return req_q.size() < TAIL_ITEMS;
	endfunction

	task automatic add_req(input logic [1:0] kind, input int unsigned page,
			input int unsigned offs, input int unsigned stamp,
			input int unsigned lat, input int unsigned start,
			input bit hold_back);
		access_req_t r;
		r.kind = kind;
		r.page = PAGE_IN_W'(page);
		r.offs = OFF_W'(offs);
		r.stamp = STAMP_W'(stamp);
		r.lat = LAT_W'(lat);
		r.start = START_W'(start);
		r.hold_back = hold_back;
		req_q.push_back(r);
	endtask

	// works out the deltas a request yields and updates the ring copy
	task automatic predict_deltas(input access_req_t r);
		int unsigned i;
		int unsigned h;
		int n;
		bit ok;
		bit dup;
		bit done;
		longint unsigned bias;
		longint unsigned last_t;
		longint unsigned req_t;
		longint unsigned window;
		longint unsigned t_i;
		delta_res_t res;
		h = ring_ptr % HISTORY_ENTRIES;
		ok = (int'(r.page) < PAGE_SLOTS) && (int'(r.offs) < BLOCKS_PER_PAGE);
		n = 0;
		done = 1'b0;
		case (r.kind)
		REQ_INSERT: begin
			dup = 1'b0;
			for (i = 0; i < HISTORY_ENTRIES; i++)
				if (ring_page[i] == PG_W'(r.page) && ring_off[i] == r.offs)
					dup = 1'b1;
			if (ok && !dup) begin
				ring_page[h] = PG_W'(r.page);
				ring_off[h] = r.offs;
				ring_time[h] = r.stamp;
				ring_ptr = (h + 1) % HISTORY_ENTRIES;
			end
		end
		REQ_INVALIDATE: begin
			if (int'(r.page) < PAGE_SLOTS)
				for (i = 0; i < HISTORY_ENTRIES; i++)
					if (ring_page[i] == PG_W'(r.page))
						ring_page[i] = NULL_PAGE;
		end
		REQ_SEARCH: begin
			if (ok) begin
				bias = 0;
				req_t = 64'(r.start);
				i = (h + HISTORY_ENTRIES - 1) % HISTORY_ENTRIES;
				last_t = 64'(ring_time[i]);
				while (i != h && !done) begin
					t_i = 64'(ring_time[i]);
					// an older entry with a later stamp means the clock wrapped
					if (last_t < t_i)
						bias = 64'd1 << TIME_BITS;
					last_t = t_i;
					if (ring_page[i] == PG_W'(r.page)) begin
						if (ring_off[i] == r.offs) begin
							req_t = t_i;
						end else if (req_t != 0) begin
							window = req_t + bias - 64'(r.lat);
							if (t_i <= window) begin
								n++;
								res.delta = DELTA_W'(int'(r.offs) - int'(ring_off[i]));
								res.saved = r.lat;
								res.found = 1'b1;
								res.last = (n == MAX_DELTAS);
								delta_q.push_back(res);
								done = (n == MAX_DELTAS);
							end
						end
					end
					i = (i + HISTORY_ENTRIES - 1) % HISTORY_ENTRIES;
				end
			end
			if (!done) begin
				res.delta = '0;
				res.saved = '0;
				res.found = 1'b0;
				res.last = 1'b1;
				delta_q.push_back(res);
			end
		end
		default: ;
		endcase
	endtask

	// monitor: takes input transactions into the predictor, checks results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			items_taken = 0;
			ring_ptr = 0;
			for (int k = 0; k < HISTORY_ENTRIES; k++) begin
				ring_page[k] = NULL_PAGE;
				ring_off[k] = '0;
				ring_time[k] = '0;
			end
		end else begin : mon
			delta_res_t want;
			access_req_t got;
			in_fire <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (delta_q.size() == 0) begin
					$display("%0t: result with none expected: delta %0d gain %0d found %0b last %0b",
						$time, delta, cycle_gain, found, last_of_run);
					errors++;
				end else begin
					want = delta_q.pop_front();
					if (delta !== want.delta) begin
						$display("%0t: delta expected %0d actual %0d", $time, want.delta, delta);
						errors++;
					end
					if (cycle_gain !== want.saved) begin
						$display("%0t: cycle_gain expected %0d actual %0d",
							$time, want.saved, cycle_gain);
						errors++;
					end
					if (found !== want.found) begin
						$display("%0t: found expected %0b actual %0b", $time, want.found, found);
						errors++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %0b actual %0b",
							$time, want.last, last_of_run);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				got.kind = req_type;
				got.page = page_slot;
				got.offs = block_offset;
				got.stamp = time_stamp;
				got.lat = latency;
				got.start = start_time;
				got.hold_back = 1'b0;
				predict_deltas(got);
				items_taken++;
			end
		end
	end

	// driver: offers queued requests, payload held until the transaction goes through
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_INSERT;
			page_slot <= '0;
			block_offset <= '0;
			time_stamp <= '0;
			latency <= '0;
			start_time <= '0;
			gap_left = 0;
		end else begin : drv
			access_req_t cur;
			if (in_valid && !in_fire) begin
				// still waiting on the block
			end else if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_q.size() == 0 || (req_q[0].hold_back && delta_q.size() != 0)) begin
				in_valid <= 1'b0;
			end else if (!tail_phase() && $urandom_range(0, 11) == 0) begin
				gap_left = $urandom_range(1, 16) - 1;
				in_valid <= 1'b0;
			end else begin
				cur = req_q.pop_front();
				in_valid <= 1'b1;
				req_type <= cur.kind;
				page_slot <= cur.page;
				block_offset <= cur.offs;
				time_stamp <= cur.stamp;
				latency <= cur.lat;
				start_time <= cur.start;
			end
		end
	end

	// result side back-pressure, with one long hold-off to fill the block
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			held = 1'b0;
		end else begin
			if (!held && items_taken >= 40) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!tail_phase() && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timely_delta_history_table test failed");
			$finish;
		end
	end

	initial begin : stim
		int unsigned page;
		int unsigned offs;
		int unsigned seen[10];
		int unsigned now;
		int unsigned lat;
		int unsigned start;
		int n_rand;
		int seq;
		int burst;

		// empty table: terminator only
		add_req(REQ_SEARCH, 0, 0, 0, 0, 0, 0);
		add_req(REQ_INSERT, 0, 0, 100, 0, 0, 0);
		add_req(REQ_INSERT, 0, 5, 200, 0, 0, 0);
		add_req(REQ_INSERT, 0, 63, 300, 0, 0, 0);
		add_req(REQ_INSERT, 63, 63, 65535, 65535, 65535, 0);
		// exact duplicate, skipped
		add_req(REQ_INSERT, 0, 5, 999, 0, 0, 0);
		add_req(REQ_SEARCH, 0, 63, 0, 50, 0, 0);
		add_req(REQ_SEARCH, 0, 0, 0, 0, 1000, 0);
		// window below zero wraps and accepts everything
		add_req(REQ_SEARCH, 0, 32, 0, 65535, 1, 0);
		for (int k = 1; k <= 8; k++)
			add_req(REQ_INSERT, 1, k, k * 1000, 0, 0, 0);
		// eight deltas hit the limit, no terminator
		add_req(REQ_SEARCH, 1, 40, 0, 1, 65535, 0);
		add_req(REQ_INVALIDATE, 1, 0, 0, 0, 0, 0);
		add_req(REQ_SEARCH, 1, 40, 0, 1, 65535, 0);
		add_req(REQ_UNUSED, 63, 63, 65535, 65535, 65535, 0);
		// stamps wrap between these two, bias kicks in
		add_req(REQ_INSERT, 2, 1, 65000, 0, 0, 0);
		add_req(REQ_INSERT, 2, 2, 10, 0, 0, 0);
		add_req(REQ_SEARCH, 2, 2, 0, 100, 0, 0);
		add_req(REQ_INVALIDATE, 63, 0, 0, 0, 0, 0);

		// random part: bursts of same-page accesses followed by a search
		n_rand = 0;
		seq = 0;
		now = 1000;
		while (n_rand < 75) begin
			page = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 63);
			burst = $urandom_range(2, 9);
			for (int k = 0; k < burst; k++) begin
				offs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 63);
				now = now + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 300));
				seen[k] = offs;
				add_req(REQ_INSERT, page, offs, now, $urandom, $urandom,
					k == 0 && (seq == 0 || seq == 8));
				n_rand++;
			end
			if ($urandom_range(0, 5) == 0) begin
				add_req(REQ_INVALIDATE, ($urandom_range(0, 1) == 0) ? page : $urandom_range(0, 63),
					$urandom, $urandom, $urandom, $urandom, 0);
				n_rand++;
			end
			offs = ($urandom_range(0, 4) != 0) ? seen[$urandom_range(0, burst - 1)] :
				$urandom_range(0, 63);
			lat = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1500);
			case ($urandom_range(0, 3))
			0, 1: start = 0;
			2: start = now + $urandom_range(0, 2000);
			default: start = $urandom;
			endcase
			add_req(REQ_SEARCH, page, offs, $urandom, lat, start, 0);
			n_rand++;
			if ($urandom_range(0, 7) == 0)
				add_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
			if ($urandom_range(0, 9) == 0) begin
				add_req(2'($urandom_range(0, 2)), $urandom, $urandom, $urandom, $urandom,
					$urandom, 0);
				n_rand++;
			end
			seq++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || in_valid || delta_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("timely_delta_history_table test passed");
		else
			$display("timely_delta_history_table test failed");
		$finish;
	end

endmodule
